@@ rtl/spi_frame_byte_parser_core_defines.svh @@
// Assertion macros for the SPI frame byte parser.
// Depends on nothing; the using module must have clk and rst in scope.
`ifndef SPI_FRAME_BYTE_PARSER_CORE_DEFINES_SVH
`define SPI_FRAME_BYTE_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define SFBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define SFBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFBP_ASSERT(lbl, prop, msg)
`define SFBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/sfbp_pkg.sv @@
// Package for the SPI frame byte parser: sizes, codes, phase enum, control structs.
// No dependencies.
`timescale 1ns / 1ps

package sfbp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int MASK_W      = 64;
  localparam int CFG_IDX_W   = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_ID_MASK = 2'd2;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_ID  = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_ID   = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4,
    PH_EMIT = 3'd5
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic    start;
    logic    take_len;
    logic    take_id;
    logic    take_data;
    logic    load_err;
    status_t err_code;
    logic    load_single;
    logic    emit_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_magic;
    logic len_ok;
    logic id_ok;
    logic data_done;
    logic sum_ok;
    logic len_zero;
    logic emit_last;
    logic out_valid;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/sfbp_if.sv @@
// Channel interfaces: received bytes, parser results, config writes.
// Depends on sfbp_pkg.
`timescale 1ns / 1ps

interface sfbp_byte_if;
  import sfbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfbp_result_if;
  import sfbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BYTE_W-1:0] frame_id;
  logic [LEN_W-1:0]  frame_len;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] data_byte;
  logic              last;
  modport source (output valid, output status, output frame_id, output frame_len,
                  output byte_index, output data_byte, output last, input ready);
  modport sink   (input valid, input status, input frame_id, input frame_len,
                  input byte_index, input data_byte, input last, output ready);
endinterface

interface sfbp_cfg_if;
  import sfbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MASK_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sfbp_ctrl.sv @@
// Frame parser controller: phase state machine issuing datapath commands.
// Depends on sfbp_pkg.
`timescale 1ns / 1ps

module sfbp_ctrl
  import sfbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  phase_t phase, phase_next;
  logic   acc;

  // no byte taken while emitting or while a result waits
  assign in_ready = (phase != PH_EMIT) && !stat.out_valid;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (acc && stat.is_magic) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (acc) phase_next = stat.len_ok ? PH_ID : PH_HUNT;
      end
      PH_ID: begin
        if (acc) begin
          if (!stat.id_ok)        phase_next = PH_HUNT;
          else if (stat.len_zero) phase_next = PH_SUM;
          else                    phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (acc && stat.data_done) phase_next = PH_SUM;
      end
      PH_SUM: begin
        if (acc) phase_next = (stat.sum_ok && !stat.len_zero) ? PH_EMIT : PH_HUNT;
      end
      PH_EMIT: begin
        if (!stat.out_busy && stat.emit_last) phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.err_code = ST_GOOD;
    case (phase)
      PH_HUNT: begin
        cmd.start = acc && stat.is_magic;
      end
      PH_LEN: begin
        cmd.take_len = acc && stat.len_ok;
        cmd.load_err = acc && !stat.len_ok;
        cmd.err_code = ST_BAD_LEN;
      end
      PH_ID: begin
        cmd.take_id  = acc && stat.id_ok;
        cmd.load_err = acc && !stat.id_ok;
        cmd.err_code = ST_BAD_ID;
      end
      PH_DATA: begin
        cmd.take_data = acc;
      end
      PH_SUM: begin
        cmd.load_single = acc && stat.sum_ok && stat.len_zero;
        cmd.load_err    = acc && !stat.sum_ok;
        cmd.err_code    = ST_BAD_SUM;
      end
      PH_EMIT: begin
        cmd.emit_load = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/sfbp_datapath.sv @@
// Frame parser datapath: config registers, frame fields, checksum, payload
// store and the result register. Depends on sfbp_pkg and sfbp_if.
`timescale 1ns / 1ps

module sfbp_datapath
  import sfbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] rx_byte,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  sfbp_cfg_if.sink          cfg,
  sfbp_result_if.source     result
);

  // config
  logic [BYTE_W-1:0] start_magic;
  logic [LEN_W-1:0]  max_length;
  logic [MASK_W-1:0] valid_id_mask;

  // frame state
  logic [LEN_W-1:0]  held_length;
  logic [BYTE_W-1:0] held_id;
  logic [LEN_W-1:0]  received_count;
  logic [BYTE_W-1:0] running_sum;
  logic [IDX_W-1:0]  emit_idx, emit_idx_next;

  logic [BYTE_W-1:0] payload_store [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data;

  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  count_inc;
  logic [BYTE_W-1:0] sum_neg;

  // result register
  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_id;
  logic [LEN_W-1:0]  out_len;
  logic [IDX_W-1:0]  out_idx;
  logic [BYTE_W-1:0] out_data;
  logic              out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_magic   <= '0;
      max_length    <= LEN_W'(MAX_PAYLOAD);
      valid_id_mask <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_MAGIC:   start_magic   <= cfg.data[BYTE_W-1:0];
        REG_MAX_LENGTH:    max_length    <= cfg.data[LEN_W-1:0];
        REG_VALID_ID_MASK: valid_id_mask <= cfg.data;
        default: ;
      endcase
    end
  end

  assign limit     = (max_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : max_length;
  assign count_inc = received_count + LEN_W'(1);
  assign sum_neg   = BYTE_W'(0) - running_sum;

  assign stat.is_magic  = (rx_byte == start_magic);
  assign stat.len_ok    = (rx_byte <= {{(BYTE_W-LEN_W){1'b0}}, limit});
  assign stat.id_ok     = (rx_byte < BYTE_W'(MASK_W)) && valid_id_mask[rx_byte[LEN_W-1:0]];
  assign stat.data_done = (count_inc >= held_length);
  assign stat.sum_ok    = (sum_neg == rx_byte);
  assign stat.len_zero  = (held_length == '0);
  assign stat.emit_last = ((LEN_W'(emit_idx) + LEN_W'(1)) == held_length);
  assign stat.out_valid = out_valid;
  assign stat.out_busy  = out_valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_length    <= '0;
      held_id        <= '0;
      received_count <= '0;
      running_sum    <= '0;
      emit_idx       <= '0;
    end else begin
      emit_idx <= emit_idx_next;
      if (cmd.start) begin
        running_sum    <= '0;
        received_count <= '0;
      end
      if (cmd.take_len) begin
        held_length <= rx_byte[LEN_W-1:0];
        running_sum <= rx_byte;
      end
      if (cmd.take_id) begin
        held_id        <= rx_byte;
        running_sum    <= running_sum + rx_byte;
        received_count <= '0;
      end
      if (cmd.take_data) begin
        running_sum    <= running_sum + rx_byte;
        received_count <= count_inc;
      end
    end
  end

  always_comb begin
    emit_idx_next = emit_idx;
    if (cmd.take_id)        emit_idx_next = '0;
    else if (cmd.emit_load) emit_idx_next = emit_idx + IDX_W'(1);
  end

  // read address runs one step ahead so rd_data always matches emit_idx
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      payload_store[received_count[IDX_W-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[emit_idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_err || cmd.load_single || cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_status <= cmd.err_code;
      out_id     <= rx_byte;
      out_len    <= '0;
      out_idx    <= '0;
      out_data   <= '0;
      out_last   <= 1'b1;
    end else if (cmd.load_single) begin
      out_status <= ST_GOOD;
      out_id     <= held_id;
      out_len    <= '0;
      out_idx    <= '0;
      out_data   <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_load) begin
      out_status <= ST_GOOD;
      out_id     <= held_id;
      out_len    <= held_length;
      out_idx    <= emit_idx;
      out_data   <= rd_data;
      out_last   <= stat.emit_last;
    end
  end

  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.frame_id   = out_id;
  assign result.frame_len  = out_len;
  assign result.byte_index = out_idx;
  assign result.data_byte  = out_data;
  assign result.last       = out_last;

endmodule

@@ rtl/spi_frame_byte_parser_core.sv @@
// SPI frame byte parser: hunts for a start byte, checks length, ID and
// checksum, emits one result per payload byte (one for an empty or rejected frame). Throughput:
// one byte per cycle while no result waits; a good N-byte frame then emits N results, one per
// cycle while the sink is ready, with input stalled. Error and empty-frame results are valid
// the cycle after their byte, a non-empty frame's first result once the emit phase loads it.
// Reset: synchronous, clears phase, config registers and result valid.
`timescale 1ns / 1ps
`include "spi_frame_byte_parser_core_defines.svh"

module spi_frame_byte_parser_core
  import sfbp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sfbp_byte_if.sink     byte_in,
  sfbp_result_if.source result,
  sfbp_cfg_if.sink      cfg
);

  // Structure:
  //   sfbp_ctrl     - phase machine (hunt, length, id, payload, checksum, emit)
  //   sfbp_datapath - config regs, held length/id, running checksum,
  //                   32-byte payload store, single result register
  // The store is read one entry per cycle during emit through a registered
  // read port whose address tracks the next emit index, so emission runs at
  // one result per cycle whenever the sink is ready.
  // A byte that could make a result is only taken when the result register
  // is empty; the store needs no clearing since every read entry was written
  // by the same frame.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sfbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfbp_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (byte_in.rx_byte),
    .cmd     (cmd),
    .stat    (stat),
    .cfg     (cfg),
    .result  (result)
  );

  // a byte is never taken while a result sits in the output register
  `SFBP_ASSERT(a_no_take_while_pending, !(byte_in.ready && result.valid), "byte taken with result pending")

  // error results are single and carry no length
  `SFBP_ASSERT(a_err_single, (result.valid && result.status != ST_GOOD) |-> (result.last && result.frame_len == '0), "error result malformed")

  // final byte of a non-empty frame sits at index length minus one
  `SFBP_ASSERT(a_last_index, (result.valid && result.status == ST_GOOD && result.last && result.frame_len != '0) |-> ((LEN_W'(result.byte_index) + LEN_W'(1)) == result.frame_len), "last index mismatch")

  // a new result only appears after a taken byte or while a frame emits
  `SFBP_ASSERT(a_result_cause, ($rose(result.valid) && !$past(byte_in.ready)) |-> (result.status == ST_GOOD && result.frame_len != '0), "result without cause")

endmodule
